// File: hw/rtl/zobrist_board_hash_core_assert.svh
// Assertion macros shared by the Zobrist hash RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef ZOBRIST_BOARD_HASH_CORE_ASSERT_SVH
`define ZOBRIST_BOARD_HASH_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ZBH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ZBH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/zbh_pkg.sv
// Shared constants and the xorshift32 step for the Zobrist hash core.
// No dependencies; used by zbh_keygen, zbh_key_store and zobrist_board_hash_core.
package zbh_pkg;

  localparam int unsigned SEED_W     = 32;
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned SQ_W       = 6;
  localparam int unsigned PIECE_W    = 4;
  localparam int unsigned EP_W       = 7;
  localparam int unsigned CASTLE_W   = 4;
  localparam int unsigned PART_W     = 16;

  localparam logic [SEED_W-1:0] SEED_RESET = 32'h0482_8501;

  // Keys that follow the piece keys: en passant, castling, side.
  localparam int unsigned EP_KEYS        = 16;
  localparam int unsigned CASTLE_ENTRIES = 16;
  localparam int unsigned AUX_KEYS       = EP_KEYS + CASTLE_ENTRIES;
  localparam int unsigned AUX_AW         = 5;
  localparam int unsigned EXTRA_KEYS     = AUX_KEYS + 1;

  localparam int unsigned XS_SHL_A = 13;
  localparam int unsigned XS_SHR   = 17;
  localparam int unsigned XS_SHL_B = 5;

  function automatic logic [SEED_W-1:0] xs32_next(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] t;
    t = x ^ (x << XS_SHL_A);
    t = t ^ (t >> XS_SHR);
    t = t ^ (t << XS_SHL_B);
    return t;
  endfunction

endpackage

// File: hw/rtl/zbh_keygen.sv
// Key generator and fill sequencer: one xorshift32 step per cycle, each key packing four outputs.
// Depends on zbh_pkg and the assertion macro header.
`include "zobrist_board_hash_core_assert.svh"

module zbh_keygen #(
  parameter int NUM_SQUARES     = 64,
  parameter int NUM_PIECE_KINDS = 12,
  parameter int STORE_DEPTH     = NUM_PIECE_KINDS * NUM_SQUARES + zbh_pkg::EXTRA_KEYS,
  parameter int IDX_W           = $clog2(STORE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [zbh_pkg::SEED_W-1:0]  cfg_wdata_i,
  output logic                        busy_o,
  output logic                        wr_en_o,
  output logic [IDX_W-1:0]            wr_idx_o,
  output logic [zbh_pkg::HASH_W-1:0]  wr_key_o
);
  import zbh_pkg::*;

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_FILL = 1'b1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  logic                  state_q, state_d;
  logic [SEED_W-1:0]     gen_q, gen_d;
  logic [1:0]            part_q, part_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [3*PART_W-1:0]   buf_q, buf_d;
  logic [SEED_W-1:0]     gen_nxt;

  assign gen_nxt  = xs32_next(gen_q);
  assign busy_o   = (state_q == ST_FILL);
  assign wr_en_o  = busy_o && (part_q == 2'd3);
  assign wr_idx_o = idx_q;
  // The fourth output lands in the top quarter of the key.
  assign wr_key_o = {gen_nxt[PART_W-1:0], buf_q};

  always_comb begin
    state_d = state_q;
    gen_d   = gen_q;
    part_d  = part_q;
    idx_d   = idx_q;
    buf_d   = buf_q;
    if (cfg_we_i) begin
      state_d = ST_FILL;
      gen_d   = cfg_wdata_i;
      part_d  = 2'd0;
      idx_d   = '0;
    end else if (state_q == ST_FILL) begin
      gen_d  = gen_nxt;
      part_d = part_q + 2'd1;
      buf_d  = {gen_nxt[PART_W-1:0], buf_q[3*PART_W-1:PART_W]};
      if (part_q == 2'd3) begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_RUN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      gen_q   <= SEED_RESET;
      part_q  <= 2'd0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      gen_q   <= gen_d;
      part_q  <= part_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  `ZBH_ASSERT_IMP(a_idx_range, busy_o, idx_q <= LAST_IDX, "fill index ran past the store")
  `ZBH_ASSERT_NXT(a_cfg_restart, cfg_we_i, busy_o && idx_q == '0 && part_q == 2'd0,
                  "seed write did not restart the fill")
  `ZBH_ASSERT_IMP(a_fill_end, $fell(busy_o), $past(wr_en_o) && $past(idx_q) == LAST_IDX,
                  "fill ended before the last key was written")

endmodule

// File: hw/rtl/zbh_key_store.sv
// Key store: piece-key memory, a two-port table of en-passant and castling keys,
// and the side key register. Depends on zbh_pkg.
module zbh_key_store #(
  parameter int NUM_SQUARES     = 64,
  parameter int NUM_PIECE_KINDS = 12,
  parameter int PIECE_ENTRIES   = NUM_PIECE_KINDS * NUM_SQUARES,
  parameter int PIECE_AW        = $clog2(PIECE_ENTRIES),
  parameter int IDX_W           = $clog2(PIECE_ENTRIES + zbh_pkg::EXTRA_KEYS)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_idx_i,
  input  logic [zbh_pkg::HASH_W-1:0]  wr_key_i,
  input  logic                        rd_en_i,
  input  logic [PIECE_AW-1:0]         piece_addr_i,
  input  logic [zbh_pkg::AUX_AW-1:0]  ep_addr_i,
  input  logic [zbh_pkg::AUX_AW-1:0]  castle_addr_i,
  output logic [zbh_pkg::HASH_W-1:0]  piece_key_o,
  output logic [zbh_pkg::HASH_W-1:0]  ep_key_o,
  output logic [zbh_pkg::HASH_W-1:0]  castle_key_o,
  output logic [zbh_pkg::HASH_W-1:0]  stm_key_o
);
  import zbh_pkg::*;

  logic [HASH_W-1:0] piece_mem [PIECE_ENTRIES];
  logic [HASH_W-1:0] aux_mem [AUX_KEYS];
  logic [HASH_W-1:0] piece_rd_q, ep_rd_q, castle_rd_q, stm_key_q;
  logic              wr_piece, wr_aux, wr_side;
  logic [IDX_W-1:0]  aux_off;

  assign aux_off  = wr_idx_i - IDX_W'(PIECE_ENTRIES);
  assign wr_piece = wr_en_i && (wr_idx_i < IDX_W'(PIECE_ENTRIES));
  assign wr_aux   = wr_en_i && !wr_piece && (wr_idx_i < IDX_W'(PIECE_ENTRIES + AUX_KEYS));
  assign wr_side  = wr_en_i && !wr_piece && !wr_aux;

  // Writes happen only during a fill and read data is used only outside it, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (wr_piece) begin
      piece_mem[wr_idx_i[PIECE_AW-1:0]] <= wr_key_i;
    end
    if (rd_en_i) begin
      piece_rd_q <= piece_mem[piece_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_aux) begin
      aux_mem[aux_off[AUX_AW-1:0]] <= wr_key_i;
    end
    if (rd_en_i) begin
      ep_rd_q     <= aux_mem[ep_addr_i];
      castle_rd_q <= aux_mem[castle_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_side) begin
      stm_key_q <= wr_key_i;
    end
  end

  assign piece_key_o  = piece_rd_q;
  assign ep_key_o     = ep_rd_q;
  assign castle_key_o = castle_rd_q;
  assign stm_key_o    = stm_key_q;

endmodule

// File: hw/rtl/zobrist_board_hash_core.sv
// Zobrist board hash core: hashes a board from its square items; after the last item,
// the hash passes stage 1 into the output register. Throughput is one item per cycle, set by
// the single read port of the piece-key memory, while no fill runs and no last item waits.
// After reset, and after every seed write, the key store is refilled, one generator step
// per cycle; s_axis_tready_o stays low until the fill is done.
// Depends on zbh_pkg, zbh_keygen, zbh_key_store and the assertion macro header.
`include "zobrist_board_hash_core_assert.svh"

module zobrist_board_hash_core #(
  parameter int NUM_SQUARES     = 64,
  parameter int NUM_PIECE_KINDS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [zbh_pkg::SEED_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // From bit 0: square[5:0], piece[9:6], side[10], en-passant square[17:11],
  // castling rights[21:18], zero padding[23:22].
  input  logic [zbh_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // From bit 0: hash[63:0].
  output logic [zbh_pkg::HASH_W-1:0]      m_axis_tdata_o
);
  import zbh_pkg::*;

  localparam int PIECE_ENTRIES = NUM_PIECE_KINDS * NUM_SQUARES;
  localparam int STORE_DEPTH   = PIECE_ENTRIES + EXTRA_KEYS;
  localparam int PIECE_AW      = $clog2(PIECE_ENTRIES);
  localparam int IDX_W         = $clog2(STORE_DEPTH);

  logic [SQ_W-1:0]        square;
  logic [PIECE_W-1:0]     piece;
  logic                   side;
  logic signed [EP_W-1:0] ep_target;
  logic [CASTLE_W-1:0]    castle_rights;

  logic                   fill_busy, wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [HASH_W-1:0]      wr_key;

  logic                   in_accept, pipe_en, s1_retire, out_free;
  logic                   piece_hit;
  logic [31:0]            addr_full;
  logic [PIECE_AW-1:0]    piece_addr;
  logic [AUX_AW-1:0]      ep_addr, castle_addr;
  logic [HASH_W-1:0]      piece_key, ep_key, castle_key, stm_key;
  logic [HASH_W-1:0]      piece_term, final_hash;

  logic                   s1_valid_q, s1_last_q, s1_hit_q, s1_ep_q, s1_side_q;
  logic [HASH_W-1:0]      acc_q, acc_d;
  logic                   out_valid_q;
  logic [HASH_W-1:0]      out_data_q;

  assign square        = s_axis_tdata_i[5:0];
  assign piece         = s_axis_tdata_i[9:6];
  assign side          = s_axis_tdata_i[10];
  assign ep_target     = s_axis_tdata_i[17:11];
  assign castle_rights = s_axis_tdata_i[21:18];

  zbh_keygen #(
    .NUM_SQUARES     (NUM_SQUARES),
    .NUM_PIECE_KINDS (NUM_PIECE_KINDS),
    .STORE_DEPTH     (STORE_DEPTH),
    .IDX_W           (IDX_W)
  ) u_keygen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (fill_busy),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .wr_key_o    (wr_key)
  );

  // Stage 0: address generation and memory read.
  assign piece_hit = (int'(piece) < NUM_PIECE_KINDS) && (int'(square) < NUM_SQUARES);
  assign addr_full = 32'(piece) * 32'(NUM_SQUARES) + 32'(square);
  assign piece_addr = piece_hit ? addr_full[PIECE_AW-1:0] : '0;
  assign ep_addr     = {1'b0, side, ep_target[2:0]};
  assign castle_addr = {1'b1, castle_rights};

  zbh_key_store #(
    .NUM_SQUARES     (NUM_SQUARES),
    .NUM_PIECE_KINDS (NUM_PIECE_KINDS),
    .PIECE_ENTRIES   (PIECE_ENTRIES),
    .PIECE_AW        (PIECE_AW),
    .IDX_W           (IDX_W)
  ) u_store (
    .clk_i         (clk_i),
    .wr_en_i       (wr_en),
    .wr_idx_i      (wr_idx),
    .wr_key_i      (wr_key),
    .rd_en_i       (pipe_en),
    .piece_addr_i  (piece_addr),
    .ep_addr_i     (ep_addr),
    .castle_addr_i (castle_addr),
    .piece_key_o   (piece_key),
    .ep_key_o      (ep_key),
    .castle_key_o  (castle_key),
    .stm_key_o     (stm_key)
  );

  // Stage 1 holds the read data; only a last item waits for room in the output register.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_retire       = s1_valid_q && (!s1_last_q || out_free);
  assign pipe_en         = !s1_valid_q || s1_retire;
  assign s_axis_tready_o = !fill_busy && pipe_en;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign piece_term = s1_hit_q ? piece_key : '0;
  assign final_hash = acc_q ^ piece_term ^ (s1_ep_q ? ep_key : '0) ^ castle_key
                    ^ (s1_side_q ? stm_key : '0);

  always_comb begin
    acc_d = acc_q;
    if (cfg_we_i) begin
      acc_d = '0;
    end else if (s1_retire) begin
      acc_d = s1_last_q ? '0 : (acc_q ^ piece_term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pipe_en) begin
        s1_valid_q <= in_accept;
      end
      acc_q <= acc_d;
      if (s1_retire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_last_q <= s_axis_tlast_i;
      s1_hit_q  <= piece_hit;
      s1_ep_q   <= !ep_target[EP_W-1];
      s1_side_q <= side;
    end
    if (s1_retire && s1_last_q) begin
      out_data_q <= final_hash;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `ZBH_ASSERT_IMP(a_no_accept_in_fill, in_accept, !fill_busy && !wr_en,
                  "item accepted while the key store is filling")
  `ZBH_ASSERT_NXT(a_last_loads_out, s1_retire && s1_last_q, out_valid_q && acc_q == '0,
                  "last item did not produce a hash and clear the accumulator")
  `ZBH_ASSERT_IMP(a_s1_idle_in_fill, fill_busy, !s1_valid_q || $past(in_accept),
                  "stage 1 holds an item during a fill")

endmodule
